// ===== sv/siocfg_pkg.sv =====
// Package holding the shared types and constants of the Super I/O configuration space.
`timescale 1ns / 1ps

package siocfg_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int UART_BASE_W = 12;

   // Configuration register indices (byte address bits [3:2]).
   localparam logic [1:0] CSR_UART_LOW  = 2'd0;
   localparam logic [1:0] CSR_UART_HIGH = 2'd1;
   localparam logic [1:0] CSR_CHIP_ID   = 2'd2;

   localparam logic [15:0] UART_LOW_RESET  = 16'd256;
   localparam logic [15:0] UART_HIGH_RESET = 16'd4088;
   localparam logic [7:0]  CHIP_ID_RESET   = 8'h51;

   // Access kinds and port selections.
   localparam logic       ACT_WRITE  = 1'b1;
   localparam logic [1:0] PORT_INDEX = 2'd0;
   localparam logic [1:0] PORT_DATA  = 2'd1;

   // Register indices of the configuration space.
   localparam logic [7:0] IX_LDN     = 8'h07;
   localparam logic [7:0] IX_DEVID   = 8'h20;
   localparam logic [7:0] IX_ACT     = 8'h30;
   localparam logic [7:0] IX_BASE_HI = 8'h60;
   localparam logic [7:0] IX_BASE_LO = 8'h61;
   localparam logic [7:0] IX_IRQ1    = 8'h70;
   localparam logic [7:0] IX_IRQ2    = 8'h72;
   localparam logic [7:0] IX_DMA     = 8'h74;
   localparam logic [7:0] IX_MODE    = 8'hf0;
   localparam logic [7:0] IX_MODE2   = 8'hf1;

   // Logical device numbers.
   localparam logic [7:0] DEV_PAR = 8'd3;
   localparam logic [7:0] DEV_SER = 8'd4;
   localparam logic [7:0] DEV_KBD = 8'd7;

   // Change codes.
   localparam logic [3:0] CHG_NONE     = 4'd0;
   localparam logic [3:0] CHG_MODE     = 4'd1;
   localparam logic [3:0] CHG_INDEX    = 4'd2;
   localparam logic [3:0] CHG_LDN      = 4'd3;
   localparam logic [3:0] CHG_PAR      = 4'd4;
   localparam logic [3:0] CHG_UART_ACT = 4'd5;
   localparam logic [3:0] CHG_UART_BAS = 4'd6;
   localparam logic [3:0] CHG_UART_IRQ = 4'd7;
   localparam logic [3:0] CHG_UART_MOD = 4'd8;
   localparam logic [3:0] CHG_KBD_ACT  = 4'd9;
   localparam logic [3:0] CHG_KBD_IRQ  = 4'd10;
   localparam logic [3:0] CHG_MS_IRQ   = 4'd11;
   localparam logic [3:0] CHG_KBD_MOD  = 4'd12;

   // Register masks and reset values.
   localparam logic [7:0] MASK_UART_LO  = 8'hf8;
   localparam logic [7:0] MASK_UART_MOD = 8'h83;
   localparam logic [7:0] MASK_KBD_MOD  = 8'hfc;
   localparam logic [7:0] MASK_PAR_LO   = 8'hfc;
   localparam logic [7:0] PAR_MODE_RST  = 8'h3c;
   localparam logic [2:0] PAR_DMA_RST   = 3'd4;
   localparam logic [7:0] READ_IDLE     = 8'hff;

   typedef struct packed {
      logic       action;
      logic [1:0] port_select;
      logic [7:0] data_value;
   } siocfg_req_type;

   typedef struct packed {
      logic [7:0]             read_data;
      logic [3:0]             change_code;
      logic                   uart_active;
      logic [UART_BASE_W-1:0] uart_base;
      logic                   uart_base_ok;
      logic [3:0]             uart_irq;
      logic [7:0]             uart_mode;
      logic                   kbd_active;
      logic [3:0]             kbd_irq;
      logic [3:0]             mouse_irq_out;
      logic [7:0]             kbd_mode;
   } siocfg_rsp_type;

   typedef struct packed {
      logic [15:0] uart_low;
      logic [15:0] uart_high;
      logic [7:0]  chip_id;
   } siocfg_cfg_type;

   typedef struct packed {
      logic load;
   } siocfg_cmd_type;

   typedef enum logic {
      ST_EMPTY,
      ST_FULL
   } siocfg_state_type;

endpackage

// ===== sv/siocfg_csr.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module siocfg_csr
   import siocfg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output siocfg_cfg_type        cfg
);

   logic [15:0] low_ff, low_in;
   logic [15:0] high_ff, high_in;
   logic [7:0]  id_ff, id_in;
   logic        wr_en;
   logic [1:0]  reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[3:2];
   assign wr_en   = psel & penable & pwrite & pready;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      id_in   = id_ff;
      if (wr_en) begin
         unique case (reg_sel)
            CSR_UART_LOW:  low_in  = pwdata[15:0];
            CSR_UART_HIGH: high_in = pwdata[15:0];
            CSR_CHIP_ID:   id_in   = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= UART_LOW_RESET;
         high_ff <= UART_HIGH_RESET;
         id_ff   <= CHIP_ID_RESET;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
         id_ff   <= id_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_UART_LOW:  prdata = {16'd0, low_ff};
         CSR_UART_HIGH: prdata = {16'd0, high_ff};
         CSR_CHIP_ID:   prdata = {24'd0, id_ff};
         default:       prdata = '0;
      endcase
   end

   assign cfg.uart_low  = low_ff;
   assign cfg.uart_high = high_ff;
   assign cfg.chip_id   = id_ff;

endmodule

// ===== sv/siocfg_ctrl.sv =====
// Controller state machine sequencing transfers through the result register.
`timescale 1ns / 1ps

module siocfg_ctrl
   import siocfg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output siocfg_cmd_type cmd
);

   siocfg_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_EMPTY: begin
            if (req_valid) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (!rsp_stall) state_in = req_valid ? ST_FULL : ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rsp_valid = (state_ff == ST_FULL);
      req_stall = (state_ff == ST_FULL) && rsp_stall;
      cmd.load  = req_valid && !req_stall;
   end

endmodule

// ===== sv/siocfg_datapath.sv =====
// Datapath holding the configuration space registers and the result register.
`timescale 1ns / 1ps

module siocfg_datapath
   import siocfg_pkg::*;
#(
   parameter int UART_ALIGN = 8,
   parameter int ENTER_CODE = 85,
   parameter int EXIT_CODE  = 170
) (
   input  logic           clock,
   input  logic           reset,
   input  siocfg_cmd_type cmd,
   input  siocfg_req_type req,
   input  siocfg_cfg_type cfg,
   output siocfg_rsp_type rsp
);

   // Divisibility test by multiplication with a rounded-up reciprocal.
   localparam int       DIV_SHIFT = 2 * UART_BASE_W + 2;
   localparam longint   DIV_RECIP = ((64'd1 << DIV_SHIFT) + UART_ALIGN - 1) / UART_ALIGN;
   localparam int       RECIP_W   = DIV_SHIFT + 1;
   localparam int       PROD_W    = UART_BASE_W + RECIP_W;

   logic [7:0] enter_key, exit_key;
   assign enter_key = 8'(ENTER_CODE);
   assign exit_key  = 8'(EXIT_CODE);

   logic       cfg_open_ff, cfg_open_in;
   logic [7:0] reg_index_ff, reg_index_in;
   logic [7:0] device_number_ff, device_number_in;
   logic       par_activate_ff, par_activate_in;
   logic [3:0] par_base_hi_ff, par_base_hi_in;
   logic [7:0] par_base_lo_ff, par_base_lo_in;
   logic [3:0] par_irq_ff, par_irq_in;
   logic [2:0] par_dma_ff, par_dma_in;
   logic [7:0] par_mode_ff, par_mode_in;
   logic [1:0] par_mode_two_ff, par_mode_two_in;
   logic       ser_activate_ff, ser_activate_in;
   logic [3:0] ser_base_hi_ff, ser_base_hi_in;
   logic [7:0] ser_base_lo_ff, ser_base_lo_in;
   logic [3:0] ser_irq_ff, ser_irq_in;
   logic [7:0] ser_mode_ff, ser_mode_in;
   logic       kb_activate_ff, kb_activate_in;
   logic [3:0] kb_irq_ff, kb_irq_in;
   logic [3:0] ms_irq_ff, ms_irq_in;
   logic [7:0] kb_mode_ff, kb_mode_in;
   logic [7:0] read_data_ff, read_data_in;
   logic [3:0] change_code_ff, change_code_in;

   logic [7:0] v;
   logic [7:0] data_rd;

   assign v = req.data_value;

   always_comb begin
      data_rd = 8'd0;
      priority if (reg_index_ff == IX_LDN) begin
         data_rd = device_number_ff;
      end else if (reg_index_ff == IX_DEVID) begin
         data_rd = cfg.chip_id;
      end else if (reg_index_ff < IX_ACT) begin
         data_rd = 8'd0;
      end else if (device_number_ff == DEV_PAR) begin
         unique case (reg_index_ff)
            IX_ACT:     data_rd = {7'd0, par_activate_ff};
            IX_BASE_HI: data_rd = {4'd0, par_base_hi_ff};
            IX_BASE_LO: data_rd = par_base_lo_ff;
            IX_IRQ1:    data_rd = {4'd0, par_irq_ff};
            IX_DMA:     data_rd = {5'd0, par_dma_ff};
            IX_MODE:    data_rd = par_mode_ff;
            IX_MODE2:   data_rd = {6'd0, par_mode_two_ff};
            default:    data_rd = 8'd0;
         endcase
      end else if (device_number_ff == DEV_SER) begin
         unique case (reg_index_ff)
            IX_ACT:     data_rd = {7'd0, ser_activate_ff};
            IX_BASE_HI: data_rd = {4'd0, ser_base_hi_ff};
            IX_BASE_LO: data_rd = ser_base_lo_ff;
            IX_IRQ1:    data_rd = {4'd0, ser_irq_ff};
            IX_MODE:    data_rd = ser_mode_ff;
            default:    data_rd = 8'd0;
         endcase
      end else if (device_number_ff == DEV_KBD) begin
         unique case (reg_index_ff)
            IX_ACT:  data_rd = {7'd0, kb_activate_ff};
            IX_IRQ1: data_rd = {4'd0, kb_irq_ff};
            IX_IRQ2: data_rd = {4'd0, ms_irq_ff};
            IX_MODE: data_rd = kb_mode_ff;
            default: data_rd = 8'd0;
         endcase
      end else begin
         data_rd = 8'd0;
      end
   end

   always_comb begin
      cfg_open_in      = cfg_open_ff;
      reg_index_in     = reg_index_ff;
      device_number_in = device_number_ff;
      par_activate_in  = par_activate_ff;
      par_base_hi_in   = par_base_hi_ff;
      par_base_lo_in   = par_base_lo_ff;
      par_irq_in       = par_irq_ff;
      par_dma_in       = par_dma_ff;
      par_mode_in      = par_mode_ff;
      par_mode_two_in  = par_mode_two_ff;
      ser_activate_in  = ser_activate_ff;
      ser_base_hi_in   = ser_base_hi_ff;
      ser_base_lo_in   = ser_base_lo_ff;
      ser_irq_in       = ser_irq_ff;
      ser_mode_in      = ser_mode_ff;
      kb_activate_in   = kb_activate_ff;
      kb_irq_in        = kb_irq_ff;
      ms_irq_in        = ms_irq_ff;
      kb_mode_in       = kb_mode_ff;
      read_data_in     = 8'd0;
      change_code_in   = CHG_NONE;

      if (req.action != ACT_WRITE) begin
         priority if (!cfg_open_ff) read_data_in = READ_IDLE;
         else if (req.port_select == PORT_INDEX) read_data_in = reg_index_ff;
         else if (req.port_select == PORT_DATA) read_data_in = data_rd;
         else read_data_in = READ_IDLE;
      end else if (req.port_select == PORT_INDEX) begin
         priority if (!cfg_open_ff) begin
            if (v == enter_key) begin
               cfg_open_in    = 1'b1;
               change_code_in = CHG_MODE;
            end
         end else if (v == exit_key) begin
            cfg_open_in    = 1'b0;
            change_code_in = CHG_MODE;
         end else begin
            if (v != reg_index_ff) begin
               reg_index_in   = v;
               change_code_in = CHG_INDEX;
            end
         end
      end else if (req.port_select == PORT_DATA && cfg_open_ff) begin
         priority if (reg_index_ff == IX_LDN) begin
            if (v != device_number_ff) begin
               device_number_in = v;
               change_code_in   = CHG_LDN;
            end
         end else if (reg_index_ff < IX_ACT) begin
            change_code_in = CHG_NONE;
         end else if (device_number_ff == DEV_PAR) begin
            unique case (reg_index_ff)
               IX_ACT: if (v[0] != par_activate_ff) begin
                  par_activate_in = v[0];
                  change_code_in  = CHG_PAR;
               end
               IX_BASE_HI: if (v[3:0] != par_base_hi_ff) begin
                  par_base_hi_in = v[3:0];
                  change_code_in = CHG_PAR;
               end
               IX_BASE_LO: if ((v & MASK_PAR_LO) != par_base_lo_ff) begin
                  par_base_lo_in = v & MASK_PAR_LO;
                  change_code_in = CHG_PAR;
               end
               IX_IRQ1: if (v[3:0] != par_irq_ff) begin
                  par_irq_in     = v[3:0];
                  change_code_in = CHG_PAR;
               end
               IX_DMA: if (v[2:0] != par_dma_ff) begin
                  par_dma_in     = v[2:0];
                  change_code_in = CHG_PAR;
               end
               IX_MODE: if (v != par_mode_ff) begin
                  par_mode_in    = v;
                  change_code_in = CHG_PAR;
               end
               IX_MODE2: if (v[1:0] != par_mode_two_ff) begin
                  par_mode_two_in = v[1:0];
                  change_code_in  = CHG_PAR;
               end
               default: ;
            endcase
         end else if (device_number_ff == DEV_SER) begin
            unique case (reg_index_ff)
               IX_ACT: if (v[0] != ser_activate_ff) begin
                  ser_activate_in = v[0];
                  change_code_in  = CHG_UART_ACT;
               end
               IX_BASE_HI: if (v[3:0] != ser_base_hi_ff) begin
                  ser_base_hi_in = v[3:0];
                  change_code_in = CHG_UART_BAS;
               end
               IX_BASE_LO: if ((v & MASK_UART_LO) != ser_base_lo_ff) begin
                  ser_base_lo_in = v & MASK_UART_LO;
                  change_code_in = CHG_UART_BAS;
               end
               IX_IRQ1: if (v[3:0] != ser_irq_ff) begin
                  ser_irq_in     = v[3:0];
                  change_code_in = CHG_UART_IRQ;
               end
               IX_MODE: if ((v & MASK_UART_MOD) != ser_mode_ff) begin
                  ser_mode_in    = v & MASK_UART_MOD;
                  change_code_in = CHG_UART_MOD;
               end
               default: ;
            endcase
         end else if (device_number_ff == DEV_KBD) begin
            unique case (reg_index_ff)
               IX_ACT: if (v[0] != kb_activate_ff) begin
                  kb_activate_in = v[0];
                  change_code_in = CHG_KBD_ACT;
               end
               IX_IRQ1: if (v[3:0] != kb_irq_ff) begin
                  kb_irq_in      = v[3:0];
                  change_code_in = CHG_KBD_IRQ;
               end
               IX_IRQ2: if (v[3:0] != ms_irq_ff) begin
                  ms_irq_in      = v[3:0];
                  change_code_in = CHG_MS_IRQ;
               end
               IX_MODE: if ((v & MASK_KBD_MOD) != kb_mode_ff) begin
                  kb_mode_in     = v & MASK_KBD_MOD;
                  change_code_in = CHG_KBD_MOD;
               end
               default: ;
            endcase
         end else begin
            change_code_in = CHG_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_open_ff      <= 1'b0;
         reg_index_ff     <= 8'd0;
         device_number_ff <= 8'd0;
         par_activate_ff  <= 1'b0;
         par_base_hi_ff   <= 4'd0;
         par_base_lo_ff   <= 8'd0;
         par_irq_ff       <= 4'd0;
         par_dma_ff       <= PAR_DMA_RST;
         par_mode_ff      <= PAR_MODE_RST;
         par_mode_two_ff  <= 2'd0;
         ser_activate_ff  <= 1'b0;
         ser_base_hi_ff   <= 4'd0;
         ser_base_lo_ff   <= 8'd0;
         ser_irq_ff       <= 4'd0;
         ser_mode_ff      <= 8'd0;
         kb_activate_ff   <= 1'b0;
         kb_irq_ff        <= 4'd0;
         ms_irq_ff        <= 4'd0;
         kb_mode_ff       <= 8'd0;
      end else if (cmd.load) begin
         cfg_open_ff      <= cfg_open_in;
         reg_index_ff     <= reg_index_in;
         device_number_ff <= device_number_in;
         par_activate_ff  <= par_activate_in;
         par_base_hi_ff   <= par_base_hi_in;
         par_base_lo_ff   <= par_base_lo_in;
         par_irq_ff       <= par_irq_in;
         par_dma_ff       <= par_dma_in;
         par_mode_ff      <= par_mode_in;
         par_mode_two_ff  <= par_mode_two_in;
         ser_activate_ff  <= ser_activate_in;
         ser_base_hi_ff   <= ser_base_hi_in;
         ser_base_lo_ff   <= ser_base_lo_in;
         ser_irq_ff       <= ser_irq_in;
         ser_mode_ff      <= ser_mode_in;
         kb_activate_ff   <= kb_activate_in;
         kb_irq_ff        <= kb_irq_in;
         ms_irq_ff        <= ms_irq_in;
         kb_mode_ff       <= kb_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         read_data_ff   <= read_data_in;
         change_code_ff <= change_code_in;
      end
   end

   // The summary follows the device registers, which only move on a new transfer.
   logic [UART_BASE_W-1:0] uart_base;
   logic [PROD_W-1:0]      align_prod;
   logic                   align_ok;
   logic                   range_ok;

   assign uart_base  = {ser_base_hi_ff, ser_base_lo_ff};
   assign align_prod = PROD_W'(uart_base) * PROD_W'(DIV_RECIP);
   assign align_ok   = RECIP_W'(align_prod[DIV_SHIFT-1:0]) < RECIP_W'(DIV_RECIP);
   assign range_ok   = (16'(uart_base) >= cfg.uart_low) && (16'(uart_base) <= cfg.uart_high);

   assign rsp.read_data     = read_data_ff;
   assign rsp.change_code   = change_code_ff;
   assign rsp.uart_active   = ser_activate_ff;
   assign rsp.uart_base     = uart_base;
   assign rsp.uart_base_ok  = range_ok && align_ok;
   assign rsp.uart_irq      = ser_irq_ff;
   assign rsp.uart_mode     = ser_mode_ff;
   assign rsp.kbd_active    = kb_activate_ff;
   assign rsp.kbd_irq       = kb_irq_ff;
   assign rsp.mouse_irq_out = ms_irq_ff;
   assign rsp.kbd_mode      = kb_mode_ff;

endmodule

// ===== sv/superio_config_space.sv =====
// Top level of the Super I/O index/data configuration space.
`timescale 1ns / 1ps

// Each bus access arrives as one request transfer and gives exactly one response
// transfer, presented from the result register in the cycle after it is accepted. While
// the response is taken in the same cycle, a new request is accepted every cycle, so
// the sustained rate is one access per clock; a stalled response holds the request
// side for as long as it is stalled. The UART and keyboard summary reflects the
// device registers after the access. The user must write configuration registers through
// the APB-style port only while no response is pending; the block does not enforce this.
module superio_config_space
   import siocfg_pkg::*;
#(
   parameter int UART_ALIGN = 8,
   parameter int ENTER_CODE = 85,
   parameter int EXIT_CODE  = 170
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  siocfg_req_type        req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output siocfg_rsp_type        rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   siocfg_cmd_type cmd;
   siocfg_cfg_type cfg;

   siocfg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   siocfg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   siocfg_datapath #(
      .UART_ALIGN (UART_ALIGN),
      .ENTER_CODE (ENTER_CODE),
      .EXIT_CODE  (EXIT_CODE)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_data),
      .cfg   (cfg),
      .rsp   (rsp_data)
   );

endmodule
